// ===== design/nfc_pkg.sv =====
// nat flow cache package: sizes, opcodes, status codes, register indexes, hash
// used by nat_flow_cache
package nfc_pkg;
  localparam int unsigned DefBuckets = 1024;
  localparam int unsigned DefWays = 4;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [0:0] REG_LIFETIME = 1'd0;
  localparam logic [0:0] REG_LOOPBACK = 1'd1;

  localparam logic [12:0] CountMax = 13'd8191;

  function automatic logic [31:0] flow_hash(input logic [31:0] sip, input logic [31:0] dip,
                                            input logic [15:0] sp, input logic [15:0] dp);
    logic [31:0] h;
    h = ({sip[14:0], sip[31:15]} ^ dip) + ({16'd0, sp} * 32'd17)
        + ({16'd0, dp} * 32'd377);
    h = h + ~(h << 9);
    h = h ^ {h[13:0], h[31:14]};
    h = h + (h << 4);
    h = h ^ {h[9:0], h[31:10]};
    return h;
  endfunction
endpackage

// ===== design/nat_flow_cache.sv =====
// nat flow cache top level: hashed bucket store with per-way memories
// depends on nfc_pkg
//
// channel   signals                               direction
// command   start, busy, opcode .. out_interface  in, busy out
// result    done, hit .. expired_count            out, one cycle strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in, ready only when idle and no start
//
// lookup and insert go through hash/address, way read, then compare and write.
// a refused insert and an unused opcode answer in the cycle after start, with no memory read.
// a tick walks every bucket, one bucket read and write back per cycle.
// after reset a clearing pass over every bucket holds busy.
// results are shown for one cycle with done; the receiver cannot stall.
module nat_flow_cache
  import nfc_pkg::*;
#(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned WAYS = DefWays
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  input  logic [7:0]  in_interface,
  input  logic [31:0] new_src_ip,
  input  logic [31:0] new_dst_ip,
  input  logic [15:0] new_src_port,
  input  logic [15:0] new_dst_port,
  input  logic [7:0]  new_tos,
  input  logic [7:0]  out_interface,
  output logic        done,
  output logic        hit,
  output logic [1:0]  status,
  output logic [31:0] xl_src_ip,
  output logic [31:0] xl_dst_ip,
  output logic [15:0] xl_src_port,
  output logic [15:0] xl_dst_port,
  output logic [7:0]  xl_tos,
  output logic [7:0]  xl_interface,
  output logic [12:0] expired_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic        valid;
    logic [31:0] ksip;
    logic [31:0] kdip;
    logic [31:0] kports;
    logic [63:0] xips;
    logic [31:0] xports;
    logic [15:0] tosif;
    logic [15:0] ticks;
  } slot_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_TICK} state_t;

  state_t state;
  slot_t mem [WAYS][BUCKETS];
  slot_t rd [WAYS];
  logic [BW-1:0] raddr;
  logic          we;
  logic [BW-1:0] waddr;
  slot_t         wdata [WAYS];
  logic [WAYS-1:0] wmask;
  logic [BW-1:0] cnt;
  logic [15:0] lifetime;
  logic [7:0]  loopback;
  logic [1:0]  op_r;
  logic [31:0] sip_r, dip_r, xsip_r, xdip_r;
  logic [31:0] ports_r, xports_r;
  logic [15:0] tosif_r;
  logic [BW-1:0] bucket_r;
  logic [12:0] expired;
  logic        tick_last;

  logic [BW-1:0] hash_bucket;
  always_comb begin
    logic [31:0] h;
    h = flow_hash(src_ip, dst_ip, sport, dport);
    hash_bucket = BW'(h % BUCKETS);
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // way compare
  logic found, havefree;
  logic [WW-1:0] fway, freeway;
  always_comb begin
    found = 1'b0;
    havefree = 1'b0;
    fway = '0;
    freeway = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd[w].valid) begin
        if (!found && rd[w].ksip == sip_r && rd[w].kdip == dip_r && rd[w].kports == ports_r)
        begin
          found = 1'b1;
          fway = WW'(w);
        end
      end else if (!havefree) begin
        havefree = 1'b1;
        freeway = WW'(w);
      end
    end
  end

  // tick aging of one bucket
  slot_t aged [WAYS];
  logic [$clog2(WAYS+1)-1:0] nexp;
  always_comb begin
    nexp = '0;
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = rd[w];
      if (rd[w].valid) begin
        if (rd[w].ticks <= 16'd1) begin
          aged[w].valid = 1'b0;
          nexp = nexp + 1'b1;
        end else begin
          aged[w].ticks = rd[w].ticks - 16'd1;
        end
      end
    end
  end

  logic [13:0] exp_sum;
  assign exp_sum = {1'b0, expired} + 14'(nexp);

  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      rd[w] <= mem[w][raddr];
      if (we && wmask[w]) mem[w][waddr] <= wdata[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      done <= 1'b0;
      lifetime <= 16'd60;
      loopback <= 8'd0;
      we <= 1'b0;
      tick_last <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LIFETIME) lifetime <= cfg_data;
        else loopback <= cfg_data[7:0];
      end
      unique case (state)
        S_CLEAR: begin
          we <= 1'b1;
          waddr <= cnt;
          wmask <= '1;
          for (int w = 0; w < WAYS; w++) wdata[w] <= '0;
          cnt <= cnt + 1'b1;
          if (32'(cnt) == BUCKETS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r <= opcode;
            sip_r <= src_ip;
            dip_r <= dst_ip;
            ports_r <= {sport, dport};
            xsip_r <= new_src_ip;
            xdip_r <= new_dst_ip;
            xports_r <= {new_src_port, new_dst_port};
            tosif_r <= {new_tos, out_interface};
            bucket_r <= hash_bucket;
            {hit, xl_src_ip, xl_dst_ip, xl_src_port, xl_dst_port, xl_tos,
             xl_interface, expired_count} <= '0;
            if (opcode == OP_INSERT && (in_interface == loopback ||
                out_interface == loopback || in_interface == out_interface)) begin
              status <= ST_REFUSED;
            end else begin
              status <= ST_DONE;
            end
            if (opcode == OP_TICK) begin
              raddr <= '0;
              cnt <= '0;
              expired <= '0;
              tick_last <= 1'b0;
              state <= S_TICK;
            end else if (opcode == OP_LOOKUP || opcode == OP_INSERT) begin
              if (opcode == OP_INSERT && (in_interface == loopback ||
                  out_interface == loopback || in_interface == out_interface)) begin
                done <= 1'b1;
              end else begin
                raddr <= hash_bucket;
                state <= S_READ;
              end
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (found) begin
            hit <= 1'b1;
            status <= (op_r == OP_INSERT) ? ST_PRESENT : ST_DONE;
            {xl_src_ip, xl_dst_ip} <= rd[fway].xips;
            {xl_src_port, xl_dst_port} <= rd[fway].xports;
            {xl_tos, xl_interface} <= rd[fway].tosif;
          end else if (op_r == OP_INSERT) begin
            if (!havefree) begin
              status <= ST_FULL;
            end else begin
              we <= 1'b1;
              waddr <= bucket_r;
              for (int w = 0; w < WAYS; w++) begin
                wmask[w] <= (WW'(w) == freeway);
                wdata[w] <= '{valid: 1'b1, ksip: sip_r, kdip: dip_r, kports: ports_r,
                              xips: {xsip_r, xdip_r}, xports: xports_r,
                              tosif: tosif_r, ticks: lifetime};
              end
            end
          end
        end
        S_TICK: begin
          // raddr runs one bucket ahead of cnt; the bucket at cnt is in rd once tick_last set
          if (32'(raddr) != BUCKETS - 1) raddr <= raddr + 1'b1;
          tick_last <= 1'b1;
          if (tick_last) begin
            we <= 1'b1;
            waddr <= cnt;
            wmask <= '1;
            for (int w = 0; w < WAYS; w++) wdata[w] <= aged[w];
            expired <= exp_sum[13] ? CountMax : exp_sum[12:0];
            cnt <= cnt + 1'b1;
            if (32'(cnt) == BUCKETS - 1) begin
              expired_count <= exp_sum[13] ? CountMax : exp_sum[12:0];
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_done_while_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !done) else $error("result during clearing pass");
  a_eval_done: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |=> done) else $error("lookup without result");
  a_tick_zero_xl: assert property (@(posedge clk) disable iff (rst)
    done && expired_count != 13'd0 |-> !hit) else $error("tick reported hit");
`endif
endmodule

// ===== dv/tb_nat_flow_cache.sv =====
// testbench for nat_flow_cache: random and directed lookup, insert, tick words
// checked against an in-bench flow table model, under several config settings
// depends on nfc_pkg and nat_flow_cache
`timescale 1ns / 100ps

module tb_nat_flow_cache;
  import nfc_pkg::*;

  localparam int unsigned NBUCKETS = DefBuckets;
  localparam int unsigned NWAYS = DefWays;
  localparam int unsigned NSLOTS = NBUCKETS * NWAYS;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  iif;
    logic [31:0] nsip;
    logic [31:0] ndip;
    logic [15:0] nsp;
    logic [15:0] ndp;
    logic [7:0]  ntos;
    logic [7:0]  oif;
  } cmd_word_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  status;
    logic [31:0] xsip;
    logic [31:0] xdip;
    logic [15:0] xsp;
    logic [15:0] xdp;
    logic [7:0]  xtos;
    logic [7:0]  xif;
    logic [12:0] expired;
  } xlate_t;

  typedef struct packed {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
  } flow_key_t;

  typedef struct packed {
    logic        used;
    flow_key_t   key;
    logic [31:0] nsip;
    logic [31:0] ndip;
    logic [15:0] nsp;
    logic [15:0] ndp;
    logic [7:0]  tos;
    logic [7:0]  oif;
    logic [15:0] ttl;
  } flow_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] sport = '0;
  logic [15:0] dport = '0;
  logic [7:0]  in_interface = '0;
  logic [31:0] new_src_ip = '0;
  logic [31:0] new_dst_ip = '0;
  logic [15:0] new_src_port = '0;
  logic [15:0] new_dst_port = '0;
  logic [7:0]  new_tos = '0;
  logic [7:0]  out_interface = '0;
  logic        done;
  logic        hit;
  logic [1:0]  status;
  logic [31:0] xl_src_ip;
  logic [31:0] xl_dst_ip;
  logic [15:0] xl_src_port;
  logic [15:0] xl_dst_port;
  logic [7:0]  xl_tos;
  logic [7:0]  xl_interface;
  logic [12:0] expired_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  nat_flow_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .src_ip(src_ip), .dst_ip(dst_ip), .sport(sport), .dport(dport),
    .in_interface(in_interface), .new_src_ip(new_src_ip), .new_dst_ip(new_dst_ip),
    .new_src_port(new_src_port), .new_dst_port(new_dst_port), .new_tos(new_tos),
    .out_interface(out_interface), .done(done), .hit(hit), .status(status),
    .xl_src_ip(xl_src_ip), .xl_dst_ip(xl_dst_ip), .xl_src_port(xl_src_port),
    .xl_dst_port(xl_dst_port), .xl_tos(xl_tos), .xl_interface(xl_interface),
    .expired_count(expired_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_slot_t flow_table[NSLOTS];
  logic [15:0] lifetime_reg = 16'd60;
  logic [7:0]  loopback_reg = 8'd0;

  cmd_word_t pending_words[$];
  xlate_t    expected_xlates[$];
  flow_key_t key_pool[$];

  int unsigned n_mismatch = 0;
  int unsigned n_unexpected = 0;
  int unsigned n_words = 0;
  int unsigned n_hits = 0;
  int unsigned n_full = 0;
  int unsigned n_refused = 0;
  int unsigned n_ticks = 0;
  int unsigned n_expired = 0;
  logic        took_word = 1'b0;
  int unsigned gap_left = 0;
  bit          quiet_mode = 1'b0;

  function automatic int unsigned bucket_index(flow_key_t k);
    logic [31:0] h;
    h = (((k.sip << 17) | (k.sip >> 15)) ^ k.dip) + {16'd0, k.sp} * 32'd17
        + {16'd0, k.dp} * 32'd377;
    h = h + ~(h << 9);
    h = h ^ ((h >> 14) | (h << 18));
    h = h + (h << 4);
    h = h ^ ((h >> 10) | (h << 22));
    return h % NBUCKETS;
  endfunction

  function automatic xlate_t predict_flow(cmd_word_t w);
    xlate_t r;
    flow_key_t k;
    int unsigned base, s, hit_slot, free_slot, cnt;
    bit found, have_free;
    r = '0;
    found = 0;
    have_free = 0;
    hit_slot = 0;
    free_slot = 0;
    cnt = 0;
    k = {w.sip, w.dip, w.sp, w.dp};
    if (w.opcode == OP_TICK) begin
      for (s = 0; s < NSLOTS; s++) begin
        if (flow_table[s].used) begin
          if (flow_table[s].ttl <= 16'd1) begin
            flow_table[s].used = 1'b0;
            if (cnt < CountMax) cnt++;
          end else begin
            flow_table[s].ttl = flow_table[s].ttl - 16'd1;
          end
        end
      end
      r.expired = cnt[12:0];
      return r;
    end
    if (w.opcode == OP_NOP) return r;
    if (w.opcode == OP_INSERT && (w.iif == loopback_reg || w.oif == loopback_reg
                                  || w.iif == w.oif)) begin
      r.status = ST_REFUSED;
      return r;
    end
    base = bucket_index(k) * NWAYS;
    for (s = base; s < base + NWAYS; s++) begin
      if (flow_table[s].used) begin
        if (!found && flow_table[s].key == k) begin
          found = 1;
          hit_slot = s;
        end
      end else if (!have_free) begin
        have_free = 1;
        free_slot = s;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      r.status = (w.opcode == OP_INSERT) ? ST_PRESENT : ST_DONE;
      r.xsip = flow_table[hit_slot].nsip;
      r.xdip = flow_table[hit_slot].ndip;
      r.xsp = flow_table[hit_slot].nsp;
      r.xdp = flow_table[hit_slot].ndp;
      r.xtos = flow_table[hit_slot].tos;
      r.xif = flow_table[hit_slot].oif;
      return r;
    end
    if (w.opcode == OP_LOOKUP) return r;
    if (!have_free) begin
      r.status = ST_FULL;
      return r;
    end
    flow_table[free_slot] = {1'b1, k, w.nsip, w.ndip, w.nsp, w.ndp, w.ntos, w.oif,
                             lifetime_reg};
    return r;
  endfunction

  // monitor: check results, then model each accepted word and config write
  always @(posedge clk) begin
    xlate_t got, want;
    got = {hit, status, xl_src_ip, xl_dst_ip, xl_src_port, xl_dst_port, xl_tos,
           xl_interface, expired_count};
    if (!rst && done) begin
      if (expected_xlates.size() == 0) begin
        n_unexpected++;
        $display("error: result with nothing expected: %h", got);
      end else begin
        want = expected_xlates.pop_front();
        if (got.hit != want.hit || got.status != want.status || got.xsip != want.xsip
            || got.xdip != want.xdip || got.xsp != want.xsp || got.xdp != want.xdp
            || got.xtos != want.xtos || got.xif != want.xif
            || got.expired != want.expired) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
        if (want.hit) n_hits++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_REFUSED) n_refused++;
        n_expired += want.expired;
      end
    end
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LIFETIME) lifetime_reg = cfg_data;
      else loopback_reg = cfg_data[7:0];
    end
    if (!rst && start && !busy) begin
      expected_xlates.push_back(predict_flow({opcode, src_ip, dst_ip, sport, dport,
                                              in_interface, new_src_ip, new_dst_ip,
                                              new_src_port, new_dst_port, new_tos,
                                              out_interface}));
      n_words++;
      if (opcode == OP_TICK) n_ticks++;
    end
    took_word <= !rst && start && !busy;
  end

  // driver
  always @(negedge clk) begin
    cmd_word_t w;
    if (!rst && !(start && !took_word)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        {opcode, src_ip, dst_ip, sport, dport, in_interface, new_src_ip,
         new_dst_ip, new_src_port, new_dst_port, new_tos, out_interface} = w;
        start <= 1'b1;
        if (n_words % 40 == 0) quiet_mode = $urandom_range(0, 2) == 0;
        gap_left <= quiet_mode ? 0 : $urandom_range(0, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic cmd_word_t make_word(logic [1:0] op, flow_key_t k,
                                          logic [7:0] iif, logic [7:0] oif);
    cmd_word_t w;
    w = {op, k, iif, $urandom, $urandom, 16'($urandom), 16'($urandom),
         8'($urandom), oif};
    return w;
  endfunction

  function automatic flow_key_t random_key();
    return {$urandom, $urandom, 16'($urandom), 16'($urandom)};
  endfunction

  function automatic cmd_word_t random_word();
    int unsigned pick, ifpick;
    flow_key_t k;
    logic [1:0] op;
    logic [7:0] iif, oif;
    pick = $urandom_range(0, 99);
    if (pick < 6) op = OP_TICK;
    else if (pick < 9) op = OP_NOP;
    else if (pick < 55) op = OP_INSERT;
    else op = OP_LOOKUP;
    k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                   : random_key();
    iif = 8'($urandom);
    oif = 8'($urandom);
    ifpick = $urandom_range(0, 19);
    if (ifpick == 0) iif = loopback_reg;
    else if (ifpick == 1) oif = loopback_reg;
    else if (ifpick == 2) oif = iif;
    else begin
      if (iif == loopback_reg) iif = iif + 8'd1;
      if (oif == loopback_reg || oif == iif) oif = iif + 8'd1;
      if (oif == loopback_reg) oif = oif + 8'd1;
    end
    if (op == OP_TICK || op == OP_NOP)
      return make_word(op, random_key(), 8'($urandom), 8'($urandom));
    return make_word(op, k, iif, oif);
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || start || expected_xlates.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] life, logic [7:0] lb, int unsigned count);
    write_reg(REG_LIFETIME, life);
    write_reg(REG_LOOPBACK, {8'd0, lb});
    @(posedge clk);
    repeat (count) pending_words.push_back(random_word());
    drain();
  endtask

  initial begin
    int unsigned target;
    flow_key_t k;
    cmd_word_t w;
    for (int b = 0; b < 4; b++) begin
      target = $urandom_range(0, NBUCKETS - 1);
      for (int j = 0; j < 6; j++) begin
        k = random_key();
        while (bucket_index(k) != target) k = random_key();
        key_pool.push_back(k);
      end
    end
    repeat (16) key_pool.push_back(random_key());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed word list, default config: lifetime 60, loopback 0
    pending_words.push_back(make_word(OP_LOOKUP, key_pool[0], 8'd1, 8'd2));
    w = make_word(OP_INSERT, key_pool[0], 8'd1, 8'd2);
    {w.nsip, w.ndip, w.nsp, w.ndp, w.ntos} = '1;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_INSERT, key_pool[0], 8'd3, 8'd4));
    pending_words.push_back(make_word(OP_LOOKUP, key_pool[0], 8'd0, 8'd0));
    pending_words.push_back(make_word(OP_INSERT, key_pool[6], 8'd0, 8'd5));
    pending_words.push_back(make_word(OP_INSERT, key_pool[6], 8'd5, 8'd0));
    pending_words.push_back(make_word(OP_INSERT, key_pool[6], 8'd9, 8'd9));
    for (int j = 1; j < 6; j++)
      pending_words.push_back(make_word(OP_INSERT, key_pool[j], 8'(10 + j), 8'd20));
    pending_words.push_back(make_word(OP_LOOKUP, key_pool[4], 8'd1, 8'd2));
    pending_words.push_back(make_word(OP_LOOKUP, key_pool[3], 8'd1, 8'd2));
    w = '1;
    w.opcode = OP_NOP;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_TICK, '0, 8'd0, 8'd0));
    pending_words.push_back(make_word(OP_LOOKUP, '0, 8'd0, 8'd0));
    w = '1;
    w.opcode = OP_INSERT;
    w.oif = 8'd254;
    {w.nsip, w.ndip, w.nsp, w.ndp, w.ntos} = '0;
    pending_words.push_back(w);
    w.opcode = OP_LOOKUP;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_INSERT, '0, 8'd255, 8'd1));
    pending_words.push_back(make_word(OP_LOOKUP, '0, 8'd0, 8'd0));
    drain();

    repeat (100) pending_words.push_back(random_word());
    drain();
    run_phase(16'd1, 8'd255, 80);
    run_phase(16'd0, 8'd7, 60);
    run_phase(16'd3, 8'd128, 80);
    run_phase(16'd65535, 8'd0, 80);

    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d hits, %0d full, %0d refused, %0d ticks",
             n_words, n_hits, n_full, n_refused, n_ticks);
    $display("%0d entries aged out, %0d mismatches, %0d unexpected results",
             n_expired, n_mismatch, n_unexpected);
    if (n_mismatch == 0 && n_unexpected == 0 && expected_xlates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("error: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
